[sv/ppvc_pkg.sv]
`default_nettype none
package ppvc_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [15:0] ref_heading;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [15:0] est_heading;
    logic        [15:0] step_time;
  } ppvc_in_t;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
  } ppvc_out_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_LIN_GAINS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ANG_GAINS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VEL_LIMITS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_POS_TOL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TURN_THR = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ALLOW_REV = 3'd5;

  // divider: 33-bit magnitude shifted up by 16
  localparam int DivN = 49;
  localparam int DivCntW = 6;
  localparam int OpW = 48;
  localparam int ProdW = 65;
  localparam int AccW = 66;
  localparam int CordXW = 36;
  localparam int CordZW = 33;
  localparam int EthW = 18;

  localparam logic [15:0] DtMin = 16'd66;
  localparam logic signed [19:0] PiQ12 = 20'sd12868;
  localparam logic signed [19:0] TwoPiQ12 = 20'sd25736;
  localparam logic signed [CordZW-1:0] HalfPiQ28 = 33'sd421657428;
  localparam logic signed [OpW-1:0] TermLim = 48'sd35184372088832;

  function automatic logic signed [CordZW-1:0] atan_q28(input logic [4:0] idx);
    logic signed [CordZW-1:0] r;
    unique case (idx)
      5'd0: r = 33'sd210828714;
      5'd1: r = 33'sd124459457;
      5'd2: r = 33'sd65760959;
      5'd3: r = 33'sd33381290;
      5'd4: r = 33'sd16755422;
      5'd5: r = 33'sd8385879;
      5'd6: r = 33'sd4193963;
      5'd7: r = 33'sd2097109;
      5'd8: r = 33'sd1048571;
      5'd9: r = 33'sd524287;
      5'd10: r = 33'sd262144;
      5'd11: r = 33'sd131072;
      5'd12: r = 33'sd65536;
      5'd13: r = 33'sd32768;
      5'd14: r = 33'sd16384;
      5'd15: r = 33'sd8192;
      5'd16: r = 33'sd4096;
      5'd17: r = 33'sd2048;
      5'd18: r = 33'sd1024;
      5'd19: r = 33'sd512;
      5'd20: r = 33'sd256;
      5'd21: r = 33'sd128;
      5'd22: r = 33'sd64;
      5'd23: r = 33'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OpW-1:0] sat_term(input logic signed [OpW-1:0] v);
    logic signed [OpW-1:0] r;
    if (v > TermLim) r = TermLim;
    else if (v < -TermLim) r = -TermLim;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/planar_pid_velocity_controller.sv]
// a control beat raises its result after a restoring division by step_time, the iterative
// cordic and a second restoring division by step_time, in that order; a clear beat is
// taken in idle, clears the history and gives no result
// one control beat is in work at a time: the next is taken once the result sits in the
// output register; a held result stalls the block
// reset: asynchronous active low, clears history, control state and registers to defaults
`default_nettype none
module planar_pid_velocity_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire ppvc_pkg::ppvc_in_t             in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      ppvc_pkg::ppvc_out_t            out_data_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [ppvc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ppvc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ppvc_pkg::*;

  localparam int CordCntW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_ERR   = 18'h00002,
    S_LDIV  = 18'h00004,
    S_LINT  = 18'h00008,
    S_LIACC = 18'h00010,
    S_LP    = 18'h00020,
    S_LI    = 18'h00040,
    S_LD    = 18'h00080,
    S_CINIT = 18'h00100,
    S_CORD  = 18'h00200,
    S_CFIN  = 18'h00400,
    S_ADIV  = 18'h00800,
    S_AINT  = 18'h01000,
    S_AIACC = 18'h02000,
    S_AP    = 18'h04000,
    S_AI    = 18'h08000,
    S_AD    = 18'h10000,
    S_OUT   = 18'h20000
  } state_e;

  state_e state_q, state_d;

  logic [47:0] lin_gains_q, ang_gains_q;
  logic [31:0] vel_limits_q;
  logic [30:0] pos_tol_q;
  logic [14:0] turn_thr_q;
  logic        allow_rev_q;

  logic signed [31:0]     last_lin_q;
  logic signed [EthW-1:0] last_ang_q;
  logic signed [47:0]     lin_int_q;
  logic signed [31:0]     ang_int_q;

  ppvc_in_t in_q;
  logic signed [31:0] ex_q, ey_q;
  logic signed [31:0] ex_d, ey_d;
  logic signed [OpW-1:0] dex_q, deth_q, iex_q;
  logic signed [31:0] ieth_q;
  logic signed [EthW-1:0] eth_q, eth_d;
  logic signed [AccW-1:0] acc_q, vsum_q;

  logic [15:0]        rem_q, rem_d;
  logic [DivN-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0] div_cnt_q;
  logic               div_neg_q;
  logic               div_last;
  logic [16:0]        trial;
  logic               trial_ge;
  logic signed [OpW-1:0] div_res;

  logic signed [CordXW-1:0] cx_q, cy_q;
  logic signed [CordZW-1:0] cz_q;
  logic [CordCntW-1:0]      cord_cnt_q;
  logic                     cord_zero_q;

  logic signed [16:0]      mul_a;
  logic signed [OpW-1:0]   mul_b;
  logic signed [ProdW-1:0] prod_q;

  logic               out_valid_q;
  ppvc_out_t          out_q;
  ppvc_out_t          out_d;
  logic               out_free;
  logic               dt_ok;
  logic signed [49:0] iex_d;
  logic signed [31:0] ieth_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign dt_ok       = (in_q.step_time >= DtMin);
  assign div_last    = (div_cnt_q == DivCntW'(DivN - 1));

  // saturated position errors
  always_comb begin
    logic signed [32:0] dx, dy;
    dx = $signed({in_q.ref_x[31], in_q.ref_x}) - $signed({in_q.est_x[31], in_q.est_x});
    dy = $signed({in_q.ref_y[31], in_q.ref_y}) - $signed({in_q.est_y[31], in_q.est_y});
    if (dx[32] != dx[31]) ex_d = dx[32] ? 32'sh80000000 : 32'sh7fffffff;
    else ex_d = dx[31:0];
    if (dy[32] != dy[31]) ey_d = dy[32] ? 32'sh80000000 : 32'sh7fffffff;
    else ey_d = dy[31:0];
  end

  // restoring divider step
  always_comb begin
    logic [16:0] diffv;
    trial    = {rem_q, quo_q[DivN-1]};
    trial_ge = (trial >= {1'b0, in_q.step_time});
    diffv    = trial - {1'b0, in_q.step_time};
    rem_d    = trial_ge ? diffv[15:0] : trial[15:0];
    quo_d    = {quo_q[DivN-2:0], trial_ge};
    if (!dt_ok) div_res = '0;
    else if (div_neg_q) div_res = -$signed(quo_q[OpW-1:0]);
    else div_res = $signed(quo_q[OpW-1:0]);
  end

  // heading error
  always_comb begin
    logic signed [CordZW:0] zr;
    logic signed [19:0]     e;
    logic [32:0]            ex_mag;
    logic signed [16:0]     hd;
    zr = $signed({cz_q[CordZW-1], cz_q}) + 34'sd32768;
    e  = cord_zero_q ? 20'sd0 : 20'(zr >>> 16);
    if (vsum_q < 0 && allow_rev_q) begin
      e = e + PiQ12;
      if (e >= TwoPiQ12) e = e - TwoPiQ12;
      else if (e <= -TwoPiQ12) e = e + TwoPiQ12;
      if (e > PiQ12) e = e - TwoPiQ12;
      else if (e < -PiQ12) e = e + TwoPiQ12;
    end
    ex_mag = ex_q[31] ? 33'(-$signed({ex_q[31], ex_q})) : {1'b0, ex_q};
    hd = $signed({in_q.ref_heading[15], in_q.ref_heading})
       - $signed({in_q.est_heading[15], in_q.est_heading});
    if (ex_mag < {2'b00, pos_tol_q}) eth_d = EthW'(hd);
    else eth_d = e[EthW-1:0];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_LINT: begin
        mul_a = $signed({1'b0, in_q.step_time});
        mul_b = OpW'(ex_q);
      end
      S_LIACC: begin
        mul_a = $signed({1'b0, lin_gains_q[15:0]});
        mul_b = sat_term(OpW'(ex_q));
      end
      S_LP: begin
        mul_a = $signed({1'b0, lin_gains_q[31:16]});
        mul_b = sat_term(iex_q);
      end
      S_LI: begin
        mul_a = $signed({1'b0, lin_gains_q[47:32]});
        mul_b = sat_term(dex_q);
      end
      S_AINT: begin
        mul_a = $signed({1'b0, in_q.step_time});
        mul_b = OpW'(eth_q);
      end
      S_AIACC: begin
        mul_a = $signed({1'b0, ang_gains_q[15:0]});
        mul_b = sat_term(OpW'(eth_q));
      end
      S_AP: begin
        mul_a = $signed({1'b0, ang_gains_q[31:16]});
        mul_b = sat_term(OpW'(ieth_q));
      end
      S_AI: begin
        mul_a = $signed({1'b0, ang_gains_q[47:32]});
        mul_b = sat_term(deth_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integrals
  always_comb begin
    logic signed [ProdW-17:0] ps;
    logic signed [34:0]       as;
    ps    = prod_q[ProdW-1:16];
    iex_d = 50'(lin_int_q) + 50'(ps);
    if (iex_d > 50'sh00007fffffffffff) iex_d = 50'sh00007fffffffffff;
    else if (iex_d < -50'sh000800000000000) iex_d = -50'sh000800000000000;
    as = 35'(ang_int_q) + 35'(ps);
    if (as > 35'sh07fffffff) ieth_d = 32'sh7fffffff;
    else if (as < -35'sh080000000) ieth_d = 32'sh80000000;
    else ieth_d = as[31:0];
  end

  // output commands
  always_comb begin
    logic signed [AccW-1:0] vx, wz, vmax, wmax;
    logic [EthW-1:0]        eth_mag;
    vx = vsum_q >>> 16;
    wz = acc_q >>> 8;
    vmax = $signed({{(AccW-16){1'b0}}, vel_limits_q[15:0]});
    wmax = $signed({{(AccW-16){1'b0}}, vel_limits_q[31:16]});
    eth_mag = eth_q[EthW-1] ? EthW'(-eth_q) : eth_q;
    if (eth_mag > {3'b000, turn_thr_q}) vx = '0;
    if (vx > vmax) vx = vmax;
    else if (vx < -vmax) vx = -vmax;
    if (vx > 66'sd32767) vx = 66'sd32767;
    else if (vx < -66'sd32768) vx = -66'sd32768;
    if (wz > wmax) wz = wmax;
    else if (wz < -wmax) wz = -wmax;
    if (wz > 66'sd32767) wz = 66'sd32767;
    else if (wz < -66'sd32768) wz = -66'sd32768;
    out_d.linear_velocity  = vx[15:0];
    out_d.angular_velocity = wz[15:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i && !in_data_i.kind) state_d = S_ERR;
      S_ERR:   state_d = S_LDIV;
      S_LDIV:  if (div_last) state_d = S_LINT;
      S_LINT:  state_d = S_LIACC;
      S_LIACC: state_d = S_LP;
      S_LP:    state_d = S_LI;
      S_LI:    state_d = S_LD;
      S_LD:    state_d = S_CINIT;
      S_CINIT: state_d = S_CORD;
      S_CORD:  if (cord_cnt_q == CordCntW'(CORDIC_STAGES - 1)) state_d = S_CFIN;
      S_CFIN:  state_d = S_ADIV;
      S_ADIV:  if (div_last) state_d = S_AINT;
      S_AINT:  state_d = S_AIACC;
      S_AIACC: state_d = S_AP;
      S_AP:    state_d = S_AI;
      S_AI:    state_d = S_AD;
      S_AD:    state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      lin_gains_q  <= '0;
      ang_gains_q  <= '0;
      vel_limits_q <= 32'h10000100;
      pos_tol_q    <= 31'd6554;
      turn_thr_q   <= 15'd6434;
      allow_rev_q  <= 1'b0;
      last_lin_q   <= '0;
      last_ang_q   <= '0;
      lin_int_q    <= '0;
      ang_int_q    <= '0;
      div_cnt_q    <= '0;
      cord_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_LIN_GAINS:  lin_gains_q  <= cfg_data_i;
          REG_ANG_GAINS:  ang_gains_q  <= cfg_data_i;
          REG_VEL_LIMITS: vel_limits_q <= cfg_data_i[31:0];
          REG_POS_TOL:    pos_tol_q    <= cfg_data_i[30:0];
          REG_TURN_THR:   turn_thr_q   <= cfg_data_i[14:0];
          REG_ALLOW_REV:  allow_rev_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_IDLE && in_valid_i && in_data_i.kind) begin
        last_lin_q <= '0;
        last_ang_q <= '0;
        lin_int_q  <= '0;
        ang_int_q  <= '0;
      end
      if (state_q == S_ERR || state_q == S_CFIN) div_cnt_q <= '0;
      else if (state_q == S_LDIV || state_q == S_ADIV) div_cnt_q <= div_cnt_q + 1'b1;
      if (state_q == S_CINIT) cord_cnt_q <= '0;
      else if (state_q == S_CORD) cord_cnt_q <= cord_cnt_q + 1'b1;
      if (state_q == S_OUT && out_free) begin
        last_lin_q  <= ex_q;
        last_ang_q  <= eth_q;
        lin_int_q   <= iex_q;
        ang_int_q   <= ieth_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == S_IDLE && in_valid_i) in_q <= in_data_i;
    unique case (state_q)
      S_ERR: begin
        logic signed [32:0] d;
        ex_q <= ex_d;
        ey_q <= ey_d;
        d = $signed({ex_d[31], ex_d}) - $signed({last_lin_q[31], last_lin_q});
        div_neg_q <= d[32];
        quo_q <= {(d[32] ? 33'(-d) : d), 16'h0000};
        rem_q <= '0;
      end
      S_LDIV, S_ADIV: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      S_LINT:  dex_q <= div_res;
      S_LIACC: iex_q <= iex_d[47:0];
      S_LP:    acc_q <= AccW'(prod_q);
      S_LI:    acc_q <= acc_q + AccW'(prod_q);
      S_LD:    acc_q <= acc_q + AccW'(prod_q);
      S_CINIT: begin
        vsum_q      <= acc_q;
        cord_zero_q <= (ex_q == 0) && (ey_q == 0);
        if (ex_q < 0) begin
          if (ey_q >= 0) begin
            cx_q <= CordXW'(ey_q);
            cy_q <= -CordXW'(ex_q);
            cz_q <= HalfPiQ28;
          end else begin
            cx_q <= -CordXW'(ey_q);
            cy_q <= CordXW'(ex_q);
            cz_q <= -HalfPiQ28;
          end
        end else begin
          cx_q <= CordXW'(ex_q);
          cy_q <= CordXW'(ey_q);
          cz_q <= '0;
        end
      end
      S_CORD: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + (cy_q >>> cord_cnt_q);
          cy_q <= cy_q - (cx_q >>> cord_cnt_q);
          cz_q <= cz_q + atan_q28(5'(cord_cnt_q));
        end else begin
          cx_q <= cx_q - (cy_q >>> cord_cnt_q);
          cy_q <= cy_q + (cx_q >>> cord_cnt_q);
          cz_q <= cz_q - atan_q28(5'(cord_cnt_q));
        end
      end
      S_CFIN: begin
        logic signed [EthW:0] d2;
        eth_q <= eth_d;
        d2 = $signed({eth_d[EthW-1], eth_d}) - $signed({last_ang_q[EthW-1], last_ang_q});
        div_neg_q <= d2[EthW];
        quo_q <= {14'h0000, (d2[EthW] ? 19'(-d2) : d2), 16'h0000};
        rem_q <= '0;
      end
      S_AINT:  deth_q <= div_res;
      S_AIACC: ieth_q <= ieth_d;
      S_AP:    acc_q <= AccW'(prod_q);
      S_AI:    acc_q <= acc_q + AccW'(prod_q);
      S_AD:    acc_q <= acc_q + AccW'(prod_q);
      S_OUT:   if (out_free) out_q <= out_d;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_clear_zeroes_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind |=>
      last_lin_q == 0 && last_ang_q == 0 && lin_int_q == 0 && ang_int_q == 0)
    else $error("clear beat left history");
  a_busy_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.kind |=> !in_ready_o)
    else $error("ready while a step is in work");
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");
  a_linear_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed({out_data_o.linear_velocity[15], out_data_o.linear_velocity})
      <= $signed({1'b0, vel_limits_q[15:0]}))
    else $error("linear command above limit");
`endif

endmodule
`default_nettype wire
